// ----- src/pri_pkg.sv -----
// Shared types and constants for the planar rotation interpolator.
// No dependencies; imported by the top level and its checker.
package pri_pkg;

	localparam int ATAN_LEN = 24;
	localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
		30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
		30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
		30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
	};

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [15:0] ZERO_Q14 = 16'sd0;
	localparam int REG_ZERO_THRESHOLD = 0;
	localparam logic [7:0] ZERO_THRESHOLD_RESET = 8'd1;

	typedef struct packed {
		logic pass;
		logic signed [15:0] pc;
		logic signed [15:0] ps;
	} side_t;

endpackage

// ----- src/planar_rotation_interpolator.sv -----
// Planar rotation interpolator: slerp between two directions in the plane.
// One transaction per cycle while the output is not stalled; the datapath is fully pipelined,
// with one register stage per CORDIC iteration, per square-root bit and per quotient bit;
// a stalled output freezes all stages.
// Reset clears all valid bits and sets zero_threshold to 1. Depends on pri_pkg.
module planar_rotation_interpolator #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [15:0] from_cos,
	input  logic signed [15:0] from_sin,
	input  logic signed [15:0] to_cos,
	input  logic signed [15:0] to_sin,
	input  logic signed [17:0] fraction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] result_cos,
	output logic signed [15:0] result_sin
);
	import pri_pkg::*;

	localparam int N = CORDIC_STAGES;
	localparam int VW = 50;
	localparam int ZW = 34;
	localparam int RW = 34;
	localparam int QW = 15;
	localparam int NW = 49;
	localparam int SQ_STEPS = 32;
	localparam int ST_VEC = 3;
	localparam int ST_ANG = 4 + N;
	localparam int ST_MUL = 5 + N;
	localparam int ST_PRE = 6 + N;
	localparam int ST_SQ = 7 + 2 * N;
	localparam int ST_SUM = 8 + 2 * N;
	localparam int ST_DIV = ST_SUM + SQ_STEPS + 1;
	localparam int ST_OUT = ST_DIV + QW + 1;
	localparam logic signed [ZW-1:0] PI_Z = 34'sd2147483648;
	localparam logic signed [ZW-1:0] TWO_PI_Z = 34'sd4294967296;
	localparam logic signed [RW-1:0] HALF_PI_R = 34'sd1073741824;

	logic [7:0] thr_q;
	logic [15:0] thr_sq;
	logic en;
	logic [ST_OUT:1] vld_s;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(REG_ZERO_THRESHOLD)) ? {24'b0, thr_q} : 32'b0;
	assign thr_sq = thr_q * thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ZERO_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'(REG_ZERO_THRESHOLD)) begin
			thr_q <= pwdata[7:0];
		end
	end

	assign en = !(result_valid && result_stall);
	assign item_stall = !en;
	assign result_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ST_OUT-1:1], item_valid};
		end
	end

	// stage 1: squares and conj(start)*end
	logic signed [31:0] p_cc, p_ss, p_cs, p_sc, p_aa, p_as, p_bb, p_bs;
	logic [31:0] sa_s1, sb_s1;
	logic signed [32:0] px_s1, py_s1;
	logic signed [15:0] bc_s1, bs_s1;
	logic signed [15:0] ac_s [1:ST_PRE-1];
	logic signed [15:0] as_s [1:ST_PRE-1];
	logic signed [17:0] f_s [1:ST_MUL-1];

	assign p_cc = from_cos * to_cos;
	assign p_ss = from_sin * to_sin;
	assign p_cs = from_cos * to_sin;
	assign p_sc = from_sin * to_cos;
	assign p_aa = from_cos * from_cos;
	assign p_as = from_sin * from_sin;
	assign p_bb = to_cos * to_cos;
	assign p_bs = to_sin * to_sin;

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1 <= 32'(p_aa) + 32'(p_as);
			sb_s1 <= 32'(p_bb) + 32'(p_bs);
			px_s1 <= 33'(p_cc) + 33'(p_ss);
			py_s1 <= 33'(p_cs) - 33'(p_sc);
			bc_s1 <= to_cos;
			bs_s1 <= to_sin;
			ac_s[1] <= from_cos;
			as_s[1] <= from_sin;
			f_s[1] <= fraction;
		end
	end

	genvar k;
	generate
		for (k = 2; k < ST_PRE; k++) begin : g_ab
			always_ff @(posedge clk) begin
				if (en) begin
					ac_s[k] <= ac_s[k-1];
					as_s[k] <= as_s[k-1];
				end
			end
		end
		for (k = 2; k < ST_MUL; k++) begin : g_f
			always_ff @(posedge clk) begin
				if (en) begin
					f_s[k] <= f_s[k-1];
				end
			end
		end
	endgenerate

	// stage 2: endpoint and zero-start selection, |p|^2 = |a|^2 * |b|^2
	logic [63:0] m2_s2;
	logic signed [32:0] px_s2, py_s2;
	side_t side_d;
	side_t side_s [2:ST_OUT-1];

	always_comb begin
		side_d.pass = 1'b1;
		side_d.pc = ONE_Q14;
		side_d.ps = ZERO_Q14;
		if (f_s[1][17] || f_s[1] == 18'sd0) begin
			side_d.pc = ac_s[1];
			side_d.ps = as_s[1];
		end else if (f_s[1][16]) begin
			side_d.pc = bc_s1;
			side_d.ps = bs_s1;
		end else if (sa_s1 > {16'b0, thr_sq}) begin
			side_d.pass = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s2 <= 64'(sa_s1) * 64'(sb_s1);
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			side_s[2] <= side_d;
		end
	end

	generate
		for (k = 3; k < ST_OUT; k++) begin : g_side
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	// vectoring CORDIC
	logic signed [VW-1:0] vx_s [0:N];
	logic signed [VW-1:0] vy_s [0:N];
	logic signed [ZW-1:0] vz_s [0:N];
	logic zp_s [0:N];
	logic signed [VW-1:0] px_sh, py_sh;

	assign px_sh = VW'($signed({px_s2, 16'b0}));
	assign py_sh = VW'($signed({py_s2, 16'b0}));

	always_ff @(posedge clk) begin
		if (en) begin
			zp_s[0] <= m2_s2 <= {20'b0, thr_sq, 28'b0};
			if (px_s2[32]) begin
				vx_s[0] <= -px_sh;
				vy_s[0] <= -py_sh;
				vz_s[0] <= PI_Z;
			end else begin
				vx_s[0] <= px_sh;
				vy_s[0] <= py_sh;
				vz_s[0] <= '0;
			end
		end
	end

	generate
		for (k = 0; k < N; k++) begin : g_vec
			localparam logic signed [ZW-1:0] ATZ = $signed(ZW'(ATAN_TAB[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					zp_s[k+1] <= zp_s[k];
					if (!vy_s[k][VW-1]) begin
						vx_s[k+1] <= vx_s[k] + (vy_s[k] >>> k);
						vy_s[k+1] <= vy_s[k] - (vx_s[k] >>> k);
						vz_s[k+1] <= vz_s[k] + ATZ;
					end else begin
						vx_s[k+1] <= vx_s[k] - (vy_s[k] >>> k);
						vy_s[k+1] <= vy_s[k] + (vx_s[k] >>> k);
						vz_s[k+1] <= vz_s[k] - ATZ;
					end
				end
			end
		end
	endgenerate

	// wrap the angle, scale it by the fraction
	logic signed [ZW-1:0] zw;
	logic signed [32:0] ang_s;
	logic signed [50:0] th_s;
	logic signed [50:0] th_prod;

	always_comb begin
		zw = vz_s[N];
		if (vz_s[N] > PI_Z) begin
			zw = vz_s[N] - TWO_PI_Z;
		end else if (vz_s[N] <= -PI_Z) begin
			zw = vz_s[N] + TWO_PI_Z;
		end
	end

	assign th_prod = ang_s * f_s[ST_MUL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s <= zp_s[N] ? 33'sd0 : 33'(zw);
			th_s <= th_prod + 51'sd32768;
		end
	end

	// rotation CORDIC with quarter-turn pre-rotation
	logic signed [RW-1:0] rx_s [0:N];
	logic signed [RW-1:0] ry_s [0:N];
	logic signed [RW-1:0] rt_s [0:N];
	logic signed [RW-1:0] th_r, x0, y0;

	assign th_r = RW'($signed(th_s[48:16]));
	assign x0 = RW'($signed({ac_s[ST_PRE-1], 14'b0}));
	assign y0 = RW'($signed({as_s[ST_PRE-1], 14'b0}));

	always_ff @(posedge clk) begin
		if (en) begin
			if (th_r > HALF_PI_R) begin
				rx_s[0] <= -y0;
				ry_s[0] <= x0;
				rt_s[0] <= th_r - HALF_PI_R;
			end else if (th_r < -HALF_PI_R) begin
				rx_s[0] <= y0;
				ry_s[0] <= -x0;
				rt_s[0] <= th_r + HALF_PI_R;
			end else begin
				rx_s[0] <= x0;
				ry_s[0] <= y0;
				rt_s[0] <= th_r;
			end
		end
	end

	generate
		for (k = 0; k < N; k++) begin : g_rot
			localparam logic signed [RW-1:0] ATR = $signed(RW'(ATAN_TAB[k]));
			always_ff @(posedge clk) begin
				if (en) begin
					if (!rt_s[k][RW-1]) begin
						rx_s[k+1] <= rx_s[k] - (ry_s[k] >>> k);
						ry_s[k+1] <= ry_s[k] + (rx_s[k] >>> k);
						rt_s[k+1] <= rt_s[k] - ATR;
					end else begin
						rx_s[k+1] <= rx_s[k] + (ry_s[k] >>> k);
						ry_s[k+1] <= ry_s[k] - (rx_s[k] >>> k);
						rt_s[k+1] <= rt_s[k] + ATR;
					end
				end
			end
		end
	endgenerate

	// magnitude squared
	logic signed [RW-1:0] rx_abs, ry_abs;
	logic [63:0] x2_s, y2_s;
	logic [31:0] ax_s [ST_SQ:ST_DIV-1];
	logic [31:0] ay_s [ST_SQ:ST_DIV-1];
	logic xn_s [ST_SQ:ST_OUT-1];
	logic yn_s [ST_SQ:ST_OUT-1];

	assign rx_abs = rx_s[N][RW-1] ? -rx_s[N] : rx_s[N];
	assign ry_abs = ry_s[N][RW-1] ? -ry_s[N] : ry_s[N];

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s <= 64'(rx_abs[31:0]) * 64'(rx_abs[31:0]);
			y2_s <= 64'(ry_abs[31:0]) * 64'(ry_abs[31:0]);
			ax_s[ST_SQ] <= rx_abs[31:0];
			ay_s[ST_SQ] <= ry_abs[31:0];
			xn_s[ST_SQ] <= rx_s[N][RW-1];
			yn_s[ST_SQ] <= ry_s[N][RW-1];
		end
	end

	generate
		for (k = ST_SQ + 1; k < ST_DIV; k++) begin : g_axy
			always_ff @(posedge clk) begin
				if (en) begin
					ax_s[k] <= ax_s[k-1];
					ay_s[k] <= ay_s[k-1];
				end
			end
		end
		for (k = ST_SQ + 1; k < ST_OUT; k++) begin : g_sgn
			always_ff @(posedge clk) begin
				if (en) begin
					xn_s[k] <= xn_s[k-1];
					yn_s[k] <= yn_s[k-1];
				end
			end
		end
	endgenerate

	// integer square root, one result bit per stage
	logic [63:0] sv_s [0:SQ_STEPS];
	logic [63:0] sr_s [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s[0] <= x2_s + y2_s;
			sr_s[0] <= '0;
		end
	end

	generate
		for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic [63:0] trial;
			assign trial = sr_s[k] + BIT;
			always_ff @(posedge clk) begin
				if (en) begin
					if (sv_s[k] >= trial) begin
						sv_s[k+1] <= sv_s[k] - trial;
						sr_s[k+1] <= (sr_s[k] >> 1) + BIT;
					end else begin
						sv_s[k+1] <= sv_s[k];
						sr_s[k+1] <= sr_s[k] >> 1;
					end
				end
			end
		end
	endgenerate

	// normalize: q = (|c| * 32768 + mag) / (2 * mag), one quotient bit per stage
	logic [NW-1:0] remx_s [0:QW];
	logic [NW-1:0] remy_s [0:QW];
	logic [QW-1:0] qx_s [0:QW];
	logic [QW-1:0] qy_s [0:QW];
	logic [33:0] dd_s [0:QW-1];
	logic mz_s [ST_DIV:ST_OUT-1];
	logic [31:0] mag;

	assign mag = sr_s[SQ_STEPS][31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			remx_s[0] <= NW'({ax_s[ST_DIV-1], 15'b0}) + NW'(mag);
			remy_s[0] <= NW'({ay_s[ST_DIV-1], 15'b0}) + NW'(mag);
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			dd_s[0] <= {1'b0, mag, 1'b0};
			mz_s[ST_DIV] <= mag == 32'd0;
		end
	end

	generate
		for (k = ST_DIV + 1; k < ST_OUT; k++) begin : g_mz
			always_ff @(posedge clk) begin
				if (en) begin
					mz_s[k] <= mz_s[k-1];
				end
			end
		end
		for (k = 0; k < QW - 1; k++) begin : g_dd
			always_ff @(posedge clk) begin
				if (en) begin
					dd_s[k+1] <= dd_s[k];
				end
			end
		end
		for (k = 0; k < QW; k++) begin : g_div
			localparam int SH = QW - 1 - k;
			logic [NW-1:0] dsh;
			assign dsh = {15'b0, dd_s[k]} << SH;
			always_ff @(posedge clk) begin
				if (en) begin
					if (remx_s[k] >= dsh) begin
						remx_s[k+1] <= remx_s[k] - dsh;
						qx_s[k+1] <= qx_s[k] | (QW'(1) << SH);
					end else begin
						remx_s[k+1] <= remx_s[k];
						qx_s[k+1] <= qx_s[k];
					end
					if (remy_s[k] >= dsh) begin
						remy_s[k+1] <= remy_s[k] - dsh;
						qy_s[k+1] <= qy_s[k] | (QW'(1) << SH);
					end else begin
						remy_s[k+1] <= remy_s[k];
						qy_s[k+1] <= qy_s[k];
					end
				end
			end
		end
	endgenerate

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s[ST_OUT-1].pass) begin
				result_cos <= side_s[ST_OUT-1].pc;
				result_sin <= side_s[ST_OUT-1].ps;
			end else if (mz_s[ST_OUT-1]) begin
				result_cos <= ONE_Q14;
				result_sin <= ZERO_Q14;
			end else begin
				result_cos <= xn_s[ST_OUT-1] ? -16'(qx_s[QW]) : 16'(qx_s[QW]);
				result_sin <= yn_s[ST_OUT-1] ? -16'(qy_s[QW]) : 16'(qy_s[QW]);
			end
		end
	end

endmodule

// ----- src/pri_checker.sv -----
// Port-level checker for the planar rotation interpolator, bound to the top level.
// Depends on pri_pkg and planar_rotation_interpolator.
module pri_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pready,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [15:0] result_cos,
	input logic signed [15:0] result_sin
);
	import pri_pkg::*;

	logic [15:0] one_chk;
	assign one_chk = ONE_Q14;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_cos) && $stable(result_sin))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("input stall does not follow output backpressure");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && item_stall |-> one_chk != 16'd0 && 1'b0)
		else $error("input stalled with an empty output register");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind planar_rotation_interpolator pri_checker u_pri_checker (.*);
